// ----- hw/rtl/flvp_pkg.sv -----
`timescale 1ns / 1ps
// Shared types for the FLV tag stream parser: input and result words.
package flvp_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       file_start;
	} in_word_t;

	typedef struct packed {
		logic        kind;
		logic [7:0]  tag_type;
		logic [1:0]  type_class;
		logic [31:0] size_value;
		logic [23:0] timestamp;
		logic [7:0]  timestamp_ext;
		logic        first_byte_valid;
		logic [3:0]  high_nibble;
		logic [3:0]  low_nibble;
		logic [7:0]  version;
		logic [7:0]  flags;
		logic        signature_ok;
	} out_word_t;

	localparam logic KIND_HEADER = 1'b0;
	localparam logic KIND_TAG    = 1'b1;

	localparam logic [1:0] CLASS_AUDIO   = 2'd0;
	localparam logic [1:0] CLASS_VIDEO   = 2'd1;
	localparam logic [1:0] CLASS_SCRIPT  = 2'd2;
	localparam logic [1:0] CLASS_UNKNOWN = 2'd3;

	localparam logic [7:0] TAG_AUDIO  = 8'h08;
	localparam logic [7:0] TAG_VIDEO  = 8'h09;
	localparam logic [7:0] TAG_SCRIPT = 8'h12;

endpackage

// ----- hw/rtl/flvp_stream_if.sv -----
`timescale 1ns / 1ps
// Valid/ready stream channel carrying one word of a given payload type.
interface flvp_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/flv_tag_stream_parser.sv -----
`timescale 1ns / 1ps
// Each byte is held in the input register, parsed, and its result word, if any,
// is stored in the result register. One byte is accepted per cycle while no
// result word is stalled; a stalled result word holds back only a byte that
// would produce another result.
// Reset (arst_n low) returns to the file header phase and empties both registers.
// Top level of the FLV tag stream parser.
module flv_tag_stream_parser
	import flvp_pkg::*;
(
	input logic           clk,
	input logic           arst_n,
	flvp_stream_if.sink   in_ch,
	flvp_stream_if.source out_ch
);

	logic      in_v_s1;
	in_word_t  in_s1;
	logic      produce;
	out_word_t result;
	logic      out_v_q;
	out_word_t out_q;
	logic      out_free;
	logic      advance;

	assign out_free    = !out_v_q || out_ch.ready;
	// A byte that yields no result may move on even while the result register is full.
	assign advance     = in_v_s1 && (!produce || out_free);
	assign in_ch.ready = !in_v_s1 || advance;

	flvp_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.word    (in_s1),
		.produce (produce),
		.result  (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_v_s1 <= 1'b0;
		end else if (in_ch.valid && in_ch.ready) begin
			in_v_s1 <= 1'b1;
		end else if (advance) begin
			in_v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			in_s1 <= in_ch.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (advance && produce) begin
			out_v_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && produce) begin
			out_q <= result;
		end
	end

	assign out_ch.valid = out_v_q;
	assign out_ch.data  = out_q;

endmodule

// ----- hw/rtl/flvp_parser.sv -----
`timescale 1ns / 1ps
// Byte-level parse state machine: header check, tag header capture and skipping.
module flvp_parser
	import flvp_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      step,
	input  in_word_t  word,
	output logic      produce,
	output out_word_t result
);

	localparam logic [2:0] PH_HEADER = 3'd0;
	localparam logic [2:0] PH_HSKIP  = 3'd1;
	localparam logic [2:0] PH_PREV   = 3'd2;
	localparam logic [2:0] PH_TAG    = 3'd3;
	localparam logic [2:0] PH_FIRST  = 3'd4;
	localparam logic [2:0] PH_SKIP   = 3'd5;

	logic [2:0]  phase_q, phase_d, ph;
	logic [3:0]  idx_q, idx_d, idx;
	logic        sig_q, sig_d, sig;
	logic [39:0] shift_q, shift_d, shift;
	logic [31:0] rem_q, rem_d;
	logic [7:0]  type_q, type_d;
	logic [23:0] size_q, size_d;
	logic [31:0] ts_q, ts_d;
	logic [7:0]  b;
	logic [31:0] hsize;
	logic [23:0] size_m1;
	logic [1:0]  cls;
	out_word_t   tag_res;

	assign b       = word.data_byte;
	assign hsize   = {shift[23:0], b};
	assign size_m1 = size_q - 24'd1;

	always_comb begin
		case (type_q)
			TAG_AUDIO:  cls = CLASS_AUDIO;
			TAG_VIDEO:  cls = CLASS_VIDEO;
			TAG_SCRIPT: cls = CLASS_SCRIPT;
			default:    cls = CLASS_UNKNOWN;
		endcase
	end

	always_comb begin
		tag_res               = '0;
		tag_res.kind          = KIND_TAG;
		tag_res.tag_type      = type_q;
		tag_res.type_class    = cls;
		tag_res.size_value    = {8'd0, size_q};
		tag_res.timestamp     = ts_q[23:0];
		tag_res.timestamp_ext = ts_q[31:24];
	end

	always_comb begin
		// A file start byte is parsed as header byte zero from a fresh state.
		ph    = word.file_start ? PH_HEADER : phase_q;
		idx   = word.file_start ? 4'd0 : idx_q;
		sig   = word.file_start ? 1'b1 : sig_q;
		shift = word.file_start ? 40'd0 : shift_q;

		phase_d = ph;
		idx_d   = idx;
		sig_d   = sig;
		shift_d = shift;
		rem_d   = rem_q;
		type_d  = type_q;
		size_d  = size_q;
		ts_d    = ts_q;
		produce = 1'b0;
		result  = '0;

		case (ph)
			PH_HSKIP, PH_SKIP: begin
				if (rem_q == 32'd1) begin
					phase_d = PH_PREV;
					idx_d   = 4'd0;
				end else begin
					rem_d = rem_q - 32'd1;
				end
			end
			PH_PREV: begin
				if (idx == 4'd3) begin
					phase_d = PH_TAG;
					idx_d   = 4'd0;
				end else begin
					idx_d = idx + 4'd1;
				end
			end
			PH_TAG: begin
				case (idx)
					4'd0:                  type_d = b;
					4'd1, 4'd2, 4'd3:      size_d = {size_q[15:0], b};
					4'd4, 4'd5, 4'd6:      ts_d   = {8'd0, ts_q[15:0], b};
					4'd7:                  ts_d   = {b, ts_q[23:0]};
					default:               ;
				endcase
				if (idx == 4'd10) begin
					idx_d = 4'd0;
					if ((type_q == TAG_AUDIO || type_q == TAG_VIDEO) && size_q != 24'd0) begin
						phase_d = PH_FIRST;
					end else begin
						produce = 1'b1;
						result  = tag_res;
						rem_d   = {8'd0, size_q};
						phase_d = (size_q == 24'd0) ? PH_PREV : PH_SKIP;
					end
				end else begin
					idx_d = idx + 4'd1;
				end
			end
			PH_FIRST: begin
				produce                 = 1'b1;
				result                  = tag_res;
				result.first_byte_valid = 1'b1;
				result.high_nibble      = b[7:4];
				result.low_nibble       = b[3:0];
				rem_d                   = {8'd0, size_m1};
				idx_d                   = 4'd0;
				phase_d                 = (size_m1 == 24'd0) ? PH_PREV : PH_SKIP;
			end
			default: begin
				// Header phase: signature bytes, version, flags, then 32-bit size.
				if ((idx == 4'd0 && b != 8'h46) || (idx == 4'd1 && b != 8'h4C) ||
						(idx == 4'd2 && b != 8'h56)) begin
					sig_d = 1'b0;
				end
				shift_d = {shift[31:0], b};
				if (idx == 4'd8) begin
					produce             = 1'b1;
					result.kind         = KIND_HEADER;
					result.size_value   = hsize;
					result.version      = shift[39:32];
					result.flags        = shift[31:24];
					result.signature_ok = sig;
					idx_d               = 4'd0;
					rem_d               = hsize - 32'd9;
					phase_d             = (hsize > 32'd9) ? PH_HSKIP : PH_PREV;
				end else begin
					idx_d = idx + 4'd1;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			idx_q   <= 4'd0;
			sig_q   <= 1'b1;
			shift_q <= '0;
			rem_q   <= '0;
			type_q  <= '0;
			size_q  <= '0;
			ts_q    <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			idx_q   <= idx_d;
			sig_q   <= sig_d;
			shift_q <= shift_d;
			rem_q   <= rem_d;
			type_q  <= type_d;
			size_q  <= size_d;
			ts_q    <= ts_d;
		end
	end

endmodule

// ----- hw/rtl/flvp_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for the FLV tag stream parser, bound to the top level.
module flvp_checker
	import flvp_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      out_valid,
	input logic      out_ready,
	input out_word_t out_data
);

	// A result word that is not taken stays on the port unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result word changed while stalled");

	a_header_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.kind == KIND_HEADER |->
		out_data.tag_type == 8'd0 && out_data.timestamp == 24'd0 &&
		out_data.first_byte_valid == 1'b0)
		else $error("header word carries tag fields");

	a_tag_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.kind == KIND_TAG |->
		out_data.version == 8'd0 && out_data.flags == 8'd0 &&
		out_data.signature_ok == 1'b0 && out_data.size_value[31:24] == 8'd0)
		else $error("tag word carries header fields");

	a_class: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.kind == KIND_TAG |->
		((out_data.type_class == CLASS_AUDIO) == (out_data.tag_type == TAG_AUDIO)) &&
		((out_data.type_class == CLASS_VIDEO) == (out_data.tag_type == TAG_VIDEO)) &&
		((out_data.type_class == CLASS_SCRIPT) == (out_data.tag_type == TAG_SCRIPT)))
		else $error("type class does not match tag type");

	a_first_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.first_byte_valid |->
		out_data.kind == KIND_TAG && out_data.size_value != 32'd0 &&
		(out_data.type_class == CLASS_AUDIO || out_data.type_class == CLASS_VIDEO))
		else $error("first byte reported for a tag without media data");

endmodule

bind flv_tag_stream_parser flvp_checker u_flvp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_data  (out_ch.data)
);

// ----- dv/flv_tag_stream_parser_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the FLV tag stream parser: byte stimulus, result prediction, checks.
module flv_tag_stream_parser_tb;
	import flvp_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 300000;
	localparam int unsigned RANDOM_ITEMS = 750;
	localparam int unsigned MAX_PRINTS = 40;

	localparam logic [7:0] SIG_F = 8'h46;
	localparam logic [7:0] SIG_L = 8'h4C;
	localparam logic [7:0] SIG_V = 8'h56;

	// The opening file has no file start flag, a header size below nine, full-scale
	// version and timestamp bytes, and a zero-size audio tag.
	localparam logic [7:0] INTRO [0:23] = '{
		SIG_F, SIG_L, SIG_V, 8'hFF, 8'h05, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00,
		TAG_AUDIO, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00
	};

	typedef enum logic [2:0] {
		PARSE_HEADER,
		PARSE_SKIP,
		PARSE_PREV,
		PARSE_TAG,
		PARSE_FIRST
	} parse_phase_e;

	typedef enum logic [1:0] {
		RX_OPEN,
		RX_COIN,
		RX_SPARSE,
		RX_PERIODIC
	} rx_mode_e;

	class flv_tag_scoreboard;
		parse_phase_e phase;
		int unsigned  byte_count;
		int unsigned  skip_target;
		logic [63:0]  header_shift;
		logic [7:0]   cur_type;
		logic [23:0]  cur_size;
		logic [23:0]  cur_stamp;
		logic [7:0]   cur_ext;
		bit           sig_good;
		out_word_t    expected_words[$];
		int unsigned  err_count;

		function new();
			err_count = 0;
			restart();
		endfunction

		function void restart();
			phase = PARSE_HEADER;
			byte_count = 0;
			skip_target = 0;
			header_shift = '0;
			cur_type = '0;
			cur_size = '0;
			cur_stamp = '0;
			cur_ext = '0;
			sig_good = 1'b1;
		endfunction

		function int unsigned pending();
			return expected_words.size();
		endfunction

		function logic [1:0] class_of(logic [7:0] t);
			if (t == TAG_AUDIO)
				return CLASS_AUDIO;
			if (t == TAG_VIDEO)
				return CLASS_VIDEO;
			if (t == TAG_SCRIPT)
				return CLASS_SCRIPT;
			return CLASS_UNKNOWN;
		endfunction

		function out_word_t tag_word(bit with_first, logic [7:0] b);
			out_word_t w;
			w = '0;
			w.kind = KIND_TAG;
			w.tag_type = cur_type;
			w.type_class = class_of(cur_type);
			w.size_value = {8'h00, cur_size};
			w.timestamp = cur_stamp;
			w.timestamp_ext = cur_ext;
			if (with_first) begin
				w.first_byte_valid = 1'b1;
				w.high_nibble = b[7:4];
				w.low_nibble = b[3:0];
			end
			return w;
		endfunction

		function void start_skip(int unsigned n);
			byte_count = 0;
			skip_target = n;
			phase = (n == 0) ? PARSE_PREV : PARSE_SKIP;
		endfunction

		function void note_byte(in_word_t w);
			out_word_t hw;
			logic [7:0] b;
			logic [31:0] hsize;
			b = w.data_byte;
			if (w.file_start)
				restart();
			case (phase)
				PARSE_SKIP: begin
					byte_count++;
					if (byte_count >= skip_target) begin
						byte_count = 0;
						phase = PARSE_PREV;
					end
				end
				PARSE_PREV: begin
					byte_count++;
					if (byte_count >= 4) begin
						byte_count = 0;
						cur_type = '0;
						cur_size = '0;
						cur_stamp = '0;
						cur_ext = '0;
						phase = PARSE_TAG;
					end
				end
				PARSE_TAG: begin
					if (byte_count == 0)
						cur_type = b;
					else if (byte_count <= 3)
						cur_size = {cur_size[15:0], b};
					else if (byte_count <= 6)
						cur_stamp = {cur_stamp[15:0], b};
					else if (byte_count == 7)
						cur_ext = b;
					byte_count++;
					if (byte_count >= 11) begin
						byte_count = 0;
						// Audio and video tags with data report on their first data byte.
						if ((cur_type == TAG_AUDIO || cur_type == TAG_VIDEO) && cur_size != 0) begin
							phase = PARSE_FIRST;
						end else begin
							expected_words.push_back(tag_word(1'b0, 8'h00));
							start_skip(cur_size);
						end
					end
				end
				PARSE_FIRST: begin
					expected_words.push_back(tag_word(1'b1, b));
					start_skip(cur_size - 24'd1);
				end
				default: begin
					if ((byte_count == 0 && b != SIG_F) || (byte_count == 1 && b != SIG_L) ||
							(byte_count == 2 && b != SIG_V))
						sig_good = 1'b0;
					header_shift = {header_shift[55:0], b};
					byte_count++;
					if (byte_count >= 9) begin
						hsize = header_shift[31:0];
						hw = '0;
						hw.kind = KIND_HEADER;
						hw.size_value = hsize;
						hw.version = header_shift[47:40];
						hw.flags = header_shift[39:32];
						hw.signature_ok = sig_good;
						expected_words.push_back(hw);
						start_skip(hsize > 32'd9 ? hsize - 32'd9 : 0);
					end
				end
			endcase
		endfunction

		task report_mismatch(string msg);
			if (err_count < MAX_PRINTS)
				$display("%0t ns: %s", $time, msg);
			err_count++;
		endtask

		task compare_field(string name, logic [31:0] got, logic [31:0] want);
			if (got !== want)
				report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
		endtask

		task check_word(out_word_t got);
			out_word_t want;
			if (expected_words.size() == 0) begin
				report_mismatch($sformatf("result word %0h arrived with none expected", got));
			end else begin
				want = expected_words.pop_front();
				compare_field("kind", 32'(got.kind), 32'(want.kind));
				compare_field("tag_type", 32'(got.tag_type), 32'(want.tag_type));
				compare_field("type_class", 32'(got.type_class), 32'(want.type_class));
				compare_field("size_value", got.size_value, want.size_value);
				compare_field("timestamp", 32'(got.timestamp), 32'(want.timestamp));
				compare_field("timestamp_ext", 32'(got.timestamp_ext), 32'(want.timestamp_ext));
				compare_field("first_byte_valid", 32'(got.first_byte_valid),
					32'(want.first_byte_valid));
				compare_field("high_nibble", 32'(got.high_nibble), 32'(want.high_nibble));
				compare_field("low_nibble", 32'(got.low_nibble), 32'(want.low_nibble));
				compare_field("version", 32'(got.version), 32'(want.version));
				compare_field("flags", 32'(got.flags), 32'(want.flags));
				compare_field("signature_ok", 32'(got.signature_ok), 32'(want.signature_ok));
			end
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic rx_ready = 1'b0;

	flvp_stream_if #(.T(in_word_t)) in_ch ();
	flvp_stream_if #(.T(out_word_t)) out_ch ();

	assign out_ch.ready = rx_ready;

	flv_tag_stream_parser uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	flv_tag_scoreboard sb;
	int unsigned items_sent = 0;
	int unsigned burst_left = 0;
	int unsigned cycle_count = 0;
	rx_mode_e rx_mode = RX_OPEN;
	int unsigned rx_mode_left = 0;
	logic [2:0] rx_tick = '0;

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Both channels are sampled at the rising edge, before this edge's updates land.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready)
				sb.note_byte(in_ch.data);
			if (out_ch.valid && out_ch.ready)
				sb.check_word(out_ch.data);
		end
	end

	// The receiver moves through stall modes, each held for a random stretch of cycles.
	always @(posedge clk) begin
		if (rx_mode_left == 0) begin
			rx_mode = rx_mode_e'($urandom_range(0, 3));
			rx_mode_left = $urandom_range(20, 80);
		end
		rx_mode_left--;
		rx_tick++;
		case (rx_mode)
			RX_OPEN: rx_ready <= 1'b1;
			RX_COIN: rx_ready <= 1'($urandom_range(0, 1));
			RX_SPARSE: rx_ready <= ($urandom_range(0, 3) == 0);
			default: rx_ready <= (rx_tick < 3'd5);
		endcase
	end

	task automatic send_byte(input logic [7:0] b, input logic st);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150) :
				$urandom_range(1, 16);
			if (gap != 0) begin
				in_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_ch.valid <= 1'b1;
		in_ch.data <= {b, st};
		do
			@(posedge clk);
		while (!in_ch.ready);
		items_sent++;
	endtask

	// The first edge lets the monitor note the last accepted word before polling.
	task automatic wait_drained();
		in_ch.valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	task automatic send_noise();
		int unsigned n;
		n = $urandom_range(4, 30);
		for (int i = 0; i < n; i++)
			send_byte(8'($urandom), (i == 0) || ($urandom_range(0, 15) == 0));
	endtask

	task automatic send_random_file();
		logic [7:0] fb[$];
		logic [31:0] hsize;
		logic [23:0] tsize;
		logic [7:0] ttype;
		int unsigned pick;
		int unsigned ntags;
		int unsigned ndata;
		int unsigned idx;
		bit open_end;
		open_end = 1'b0;
		pick = $urandom_range(0, 15);
		if (pick < 10)
			hsize = 32'd9;
		else if (pick < 12)
			hsize = $urandom_range(0, 8);
		else if (pick < 14)
			hsize = $urandom_range(10, 24);
		else
			hsize = $urandom;
		fb.push_back(SIG_F);
		fb.push_back(SIG_L);
		fb.push_back(SIG_V);
		if ($urandom_range(0, 7) == 0) begin
			idx = $urandom_range(0, 2);
			fb[idx] = fb[idx] ^ (8'h01 << $urandom_range(0, 7));
		end
		fb.push_back(8'($urandom));
		pick = $urandom_range(0, 3);
		fb.push_back(pick == 0 ? 8'h05 : pick == 1 ? 8'h01 : pick == 2 ? 8'h04 : 8'($urandom));
		fb.push_back(hsize[31:24]);
		fb.push_back(hsize[23:16]);
		fb.push_back(hsize[15:8]);
		fb.push_back(hsize[7:0]);
		if (hsize > 32'd24) begin
			// A header size far past the file: only the start of the skip is sent.
			repeat ($urandom_range(1, 12)) fb.push_back(8'($urandom));
			open_end = 1'b1;
		end else if (hsize > 32'd9) begin
			repeat (hsize - 9) fb.push_back(8'($urandom));
		end
		ntags = open_end ? 0 : $urandom_range(1, 4);
		for (int t = 0; t < ntags && !open_end; t++) begin
			repeat (4) fb.push_back(8'($urandom));
			pick = $urandom_range(0, 9);
			ttype = (pick < 4) ? TAG_AUDIO : (pick < 7) ? TAG_VIDEO :
				(pick < 8) ? TAG_SCRIPT : 8'($urandom);
			pick = $urandom_range(0, 11);
			if (pick < 8) begin
				tsize = 24'($urandom_range(0, 6));
			end else if (pick < 11) begin
				tsize = 24'($urandom_range(7, 30));
			end else begin
				tsize = 24'($urandom);
				open_end = 1'b1;
			end
			fb.push_back(ttype);
			fb.push_back(tsize[23:16]);
			fb.push_back(tsize[15:8]);
			fb.push_back(tsize[7:0]);
			repeat (4) fb.push_back(8'($urandom));
			pick = $urandom_range(0, 3);
			repeat (3) fb.push_back(pick == 0 ? 8'($urandom) : 8'h00);
			ndata = open_end ? $urandom_range(1, 10) : 32'(tsize);
			repeat (ndata) fb.push_back(8'($urandom));
		end
		if (!open_end && $urandom_range(0, 5) == 0)
			fb = fb[0:$urandom_range(0, fb.size() - 1)];
		else if ($urandom_range(0, 7) == 0)
			repeat ($urandom_range(1, 20)) fb.push_back(8'($urandom));
		foreach (fb[i])
			send_byte(fb[i], i == 0);
	endtask

	initial begin
		sb = new();
		in_ch.valid <= 1'b0;
		in_ch.data <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (INTRO[i])
			send_byte(INTRO[i], 1'b0);
		wait_drained();
		while (items_sent < RANDOM_ITEMS + $size(INTRO)) begin
			if ($urandom_range(0, 9) == 0)
				wait_drained();
			if ($urandom_range(0, 9) == 0)
				send_noise();
			else
				send_random_file();
		end
		wait_drained();
		repeat (16) @(posedge clk);
		if (sb.err_count == 0 && sb.pending() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
